[hw/rtl/spm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spm_pkg
// Types, sizes and codes shared by the simple pattern matcher.
// ----------------------------------------------------------------------------
package spm_pkg;

	localparam int unsigned MAX_POSITIONS = 16;
	localparam int unsigned MAX_TERMS     = 8;
	localparam int unsigned OFFSET_BITS   = 32;

	localparam int unsigned POS_IDX_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam int unsigned POS_CNT_W  = $clog2(MAX_POSITIONS + 1);
	localparam int unsigned TERM_IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int unsigned TERM_CNT_W = $clog2(MAX_TERMS + 1);

	// Input actions.
	localparam logic [1:0] ACT_PATTERN  = 2'd0;
	localparam logic [1:0] ACT_TEXT     = 2'd1;
	localparam logic [1:0] ACT_NEW_TEXT = 2'd2;

	// Result events.
	localparam logic EV_MATCH = 1'b0;
	localparam logic EV_ERROR = 1'b1;

	// Pattern syntax characters.
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [1:0] {
		KIND_LIT   = 2'd0,
		KIND_ANY   = 2'd1,
		KIND_CLASS = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic        event_res;
		logic [31:0] match_offset;
		logic [4:0]  match_length;
		logic [15:0] match_number;
		logic        limit_reached;
	} result_t;

endpackage
`default_nettype wire

[hw/rtl/simple_pattern_matcher.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// simple_pattern_matcher
// Compiles a literal / dot / bracket-class pattern and matches text against it.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle, pattern or text alike,
// while the result output is not stalled, and delivers its result through the
// input register and then the result register. The pace is set by the single
// pass that tests a text byte against all class terms of the current position
// in parallel; those terms come from a row of the term memory that is
// registered ahead, at the cursor position the previous byte left behind.
// Results are an error on a bad pattern (bad escape, unclosed bracket, too
// many positions or terms) or a match with its offset, length and running
// count; after max_matches matches, a text yields no more.
module simple_pattern_matcher (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	output logic                  item_stall,
	input  wire  spm_pkg::item_t  item,
	output logic                  result_valid,
	input  wire                   result_stall,
	output spm_pkg::result_t      result,
	input  wire                   max_matches_we,
	input  wire  [15:0]           max_matches_wdata
);

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_ESC,
		MODE_BR_OPEN,
		MODE_BR_LO,
		MODE_BR_DASH,
		MODE_DONE
	} mode_t;

	localparam int unsigned PIW = spm_pkg::POS_IDX_W;
	localparam int unsigned PCW = spm_pkg::POS_CNT_W;
	localparam int unsigned TIW = spm_pkg::TERM_IDX_W;
	localparam int unsigned TCW = spm_pkg::TERM_CNT_W;
	localparam int unsigned OFW = spm_pkg::OFFSET_BITS;
	localparam int unsigned NPOS = spm_pkg::MAX_POSITIONS;
	localparam int unsigned NTERM = spm_pkg::MAX_TERMS;

	// Input stage.
	logic            item_valid_s1;
	spm_pkg::item_t  item_s1;
	logic            s1_free;
	logic            out_free;
	logic            proc;

	// Control state.
	mode_t           mode_q;
	logic [PCW-1:0]  pos_count_q;
	logic [TCW-1:0]  cur_terms_q;
	logic [7:0]      pending_q;
	logic            bad_q;
	logic [PIW-1:0]  cursor_q;
	logic [OFW-1:0]  text_pos_q;
	logic [OFW-1:0]  start_q;
	logic [15:0]     found_q;
	logic [15:0]     max_matches_q;
	logic            result_valid_q;
	spm_pkg::result_t result_q;

	// Pattern table: one row per position.
	spm_pkg::kind_t  kind_mem  [NPOS];
	logic [TCW-1:0]  count_mem [NPOS];
	logic [7:0]      lo_mem    [NPOS][NTERM];
	logic [7:0]      hi_mem    [NPOS][NTERM];

	// Row at the cursor, read ahead into registers.
	spm_pkg::kind_t  row_kind_q;
	logic [TCW-1:0]  row_count_q;
	logic [7:0]      row_lo_q  [NTERM];
	logic [7:0]      row_hi_q  [NTERM];

	// Next-state signals.
	mode_t           eff_mode, nxt_mode;
	logic [PCW-1:0]  eff_count, nxt_count;
	logic            eff_bad, nxt_bad;
	logic [TCW-1:0]  nxt_terms;
	logic [7:0]      nxt_pending;
	logic [PIW-1:0]  nxt_cursor;
	logic [OFW-1:0]  nxt_text, nxt_start, text_inc;
	logic [15:0]     nxt_found, found_inc;
	logic [PCW-1:0]  cursor_inc;
	logic            emit;
	spm_pkg::result_t res;

	// Table write requests.
	logic            new_req, add_req, add_two, pat_fail;
	spm_pkg::kind_t  new_kind;
	logic [7:0]      add_lo, add_hi;
	logic            wr_pos, wr_add;
	logic [PIW-1:0]  wr_row;

	logic            pos_hit;
	logic            active;

	logic [7:0]      b;

	assign b        = item_s1.data_byte;
	assign out_free = !result_valid_q || !result_stall;
	assign s1_free  = !item_valid_s1 || out_free;
	assign proc     = item_valid_s1 && out_free;
	assign item_stall   = !s1_free;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign text_inc   = text_pos_q + OFW'(1);
	assign found_inc  = found_q + 16'd1;
	assign cursor_inc = PCW'(cursor_q) + PCW'(1);

	// Test of the text byte against the position under the cursor.
	always_comb begin
		pos_hit = 1'b0;
		unique case (row_kind_q)
			spm_pkg::KIND_ANY: pos_hit = 1'b1;
			spm_pkg::KIND_LIT: pos_hit = (b == row_lo_q[0]);
			default: begin
				for (int t = 0; t < NTERM; t++) begin
					if (TCW'(t) < row_count_q && b >= row_lo_q[t] && b <= row_hi_q[t]) begin
						pos_hit = 1'b1;
					end
				end
			end
		endcase
	end

	assign active = (mode_q == MODE_DONE) && !bad_q && (pos_count_q != '0) &&
			(found_q < max_matches_q);

	always_comb begin
		eff_mode    = mode_q;
		eff_count   = pos_count_q;
		eff_bad     = bad_q;
		if (mode_q == MODE_DONE) begin
			eff_mode  = MODE_NORMAL;
			eff_count = '0;
			eff_bad   = 1'b0;
		end

		nxt_mode    = mode_q;
		nxt_count   = pos_count_q;
		nxt_bad     = bad_q;
		nxt_terms   = cur_terms_q;
		nxt_pending = pending_q;
		nxt_cursor  = cursor_q;
		nxt_text    = text_pos_q;
		nxt_start   = start_q;
		nxt_found   = found_q;
		emit        = 1'b0;
		res         = '0;
		res.event_res = spm_pkg::EV_MATCH;

		new_req  = 1'b0;
		new_kind = spm_pkg::KIND_LIT;
		add_req  = 1'b0;
		add_two  = 1'b0;
		add_lo   = pending_q;
		add_hi   = pending_q;
		pat_fail = 1'b0;
		wr_pos   = 1'b0;
		wr_add   = 1'b0;
		wr_row   = PIW'(eff_count);

		if (proc) begin
			unique case (item_s1.action)
				spm_pkg::ACT_PATTERN: begin
					nxt_mode  = eff_mode;
					nxt_count = eff_count;
					nxt_bad   = eff_bad;
					if (!eff_bad) begin
						unique case (eff_mode)
							MODE_NORMAL: begin
								if (b == spm_pkg::CH_BSLASH) begin
									nxt_mode = MODE_ESC;
								end else if (b == spm_pkg::CH_DOT) begin
									new_req  = 1'b1;
									new_kind = spm_pkg::KIND_ANY;
								end else if (b == spm_pkg::CH_LBRACK) begin
									new_req  = 1'b1;
									new_kind = spm_pkg::KIND_CLASS;
									nxt_mode = MODE_BR_OPEN;
								end else begin
									new_req  = 1'b1;
								end
							end
							MODE_ESC: begin
								if (b == spm_pkg::CH_LBRACK || b == spm_pkg::CH_DOT ||
										b == spm_pkg::CH_BSLASH) begin
									nxt_mode = MODE_NORMAL;
									new_req  = 1'b1;
								end else begin
									pat_fail = 1'b1;
								end
							end
							MODE_BR_OPEN: begin
								if (b == spm_pkg::CH_RBRACK) begin
									nxt_mode = MODE_NORMAL;
								end else begin
									nxt_pending = b;
									nxt_mode    = MODE_BR_LO;
								end
							end
							MODE_BR_LO: begin
								if (b == spm_pkg::CH_DASH) begin
									nxt_mode = MODE_BR_DASH;
								end else begin
									add_req = 1'b1;
									if (b == spm_pkg::CH_RBRACK) begin
										nxt_mode = MODE_NORMAL;
									end else begin
										nxt_pending = b;
									end
								end
							end
							MODE_BR_DASH: begin
								add_req = 1'b1;
								if (b == spm_pkg::CH_RBRACK) begin
									// A dash just before the closing bracket is a term of its own.
									add_two  = 1'b1;
									nxt_mode = MODE_NORMAL;
								end else begin
									add_hi   = b;
									nxt_mode = MODE_BR_OPEN;
								end
							end
							default: ;
						endcase

						if (new_req) begin
							if (eff_count >= PCW'(NPOS)) begin
								pat_fail = 1'b1;
							end else begin
								wr_pos    = 1'b1;
								nxt_count = eff_count + PCW'(1);
								nxt_terms = '0;
							end
						end
						if (add_req) begin
							wr_row = PIW'(eff_count - PCW'(1));
							if ((add_two && cur_terms_q >= TCW'(NTERM - 1)) ||
									cur_terms_q >= TCW'(NTERM)) begin
								pat_fail = 1'b1;
							end else begin
								wr_add    = 1'b1;
								nxt_terms = add_two ? cur_terms_q + TCW'(2) :
										cur_terms_q + TCW'(1);
							end
						end
						if (pat_fail) begin
							nxt_bad       = 1'b1;
							nxt_mode      = MODE_NORMAL;
							emit          = 1'b1;
							res.event_res = spm_pkg::EV_ERROR;
						end
					end
				end
				spm_pkg::ACT_NEW_TEXT: begin
					if (mode_q != MODE_DONE) begin
						if (!bad_q && mode_q != MODE_NORMAL) begin
							nxt_bad       = 1'b1;
							emit          = 1'b1;
							res.event_res = spm_pkg::EV_ERROR;
						end
						nxt_mode = MODE_DONE;
					end
					nxt_text   = '0;
					nxt_start  = '0;
					nxt_cursor = '0;
					nxt_found  = '0;
				end
				spm_pkg::ACT_TEXT: begin
					nxt_text = text_inc;
					if (!active || !pos_hit) begin
						nxt_cursor = '0;
						nxt_start  = text_inc;
					end else if (cursor_inc >= pos_count_q) begin
						nxt_found         = found_inc;
						emit              = 1'b1;
						res.match_offset  = 32'(start_q);
						res.match_length  = 5'(pos_count_q);
						res.match_number  = found_inc;
						res.limit_reached = (found_inc >= max_matches_q);
						nxt_cursor        = '0;
						nxt_start         = text_inc;
					end else begin
						nxt_cursor = PIW'(cursor_inc);
					end
				end
				default: ;
			endcase
		end
	end

	// Pattern table writes and the look-ahead row read.
	always_ff @(posedge clk) begin
		if (wr_pos) begin
			kind_mem[wr_row]     <= new_kind;
			count_mem[wr_row]    <= '0;
			lo_mem[wr_row][0]    <= b;
			hi_mem[wr_row][0]    <= b;
		end
		if (wr_add) begin
			count_mem[wr_row] <= nxt_terms;
			lo_mem[wr_row][TIW'(cur_terms_q)] <= add_lo;
			hi_mem[wr_row][TIW'(cur_terms_q)] <= add_hi;
			if (add_two) begin
				lo_mem[wr_row][TIW'(cur_terms_q + TCW'(1))] <= spm_pkg::CH_DASH;
				hi_mem[wr_row][TIW'(cur_terms_q + TCW'(1))] <= spm_pkg::CH_DASH;
			end
		end
		row_kind_q  <= kind_mem[nxt_cursor];
		row_count_q <= count_mem[nxt_cursor];
		for (int t = 0; t < NTERM; t++) begin
			row_lo_q[t] <= lo_mem[nxt_cursor][t];
			row_hi_q[t] <= hi_mem[nxt_cursor][t];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s1_free) begin
			item_s1 <= item;
		end
		if (out_free && emit) begin
			result_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
			mode_q         <= MODE_NORMAL;
			pos_count_q    <= '0;
			cur_terms_q    <= '0;
			pending_q      <= '0;
			bad_q          <= 1'b0;
			cursor_q       <= '0;
			text_pos_q     <= '0;
			start_q        <= '0;
			found_q        <= '0;
			max_matches_q  <= 16'hFFFF;
		end else begin
			if (s1_free) begin
				item_valid_s1 <= item_valid;
			end
			if (out_free) begin
				result_valid_q <= emit;
			end
			if (max_matches_we) begin
				max_matches_q <= max_matches_wdata;
			end
			mode_q      <= nxt_mode;
			pos_count_q <= nxt_count;
			cur_terms_q <= nxt_terms;
			pending_q   <= nxt_pending;
			bad_q       <= nxt_bad;
			cursor_q    <= nxt_cursor;
			text_pos_q  <= nxt_text;
			start_q     <= nxt_start;
			found_q     <= nxt_found;
		end
	end

	// While a compiled, usable pattern is loaded, the cursor points inside it.
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_DONE && !bad_q && pos_count_q != '0) |->
			(PCW'(cursor_q) < pos_count_q))
		else $error("cursor beyond the last pattern position");

	// An error transaction leaves the pattern marked bad, so it is reported once.
	a_error_marks_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && emit && res.event_res == spm_pkg::EV_ERROR) |=> bad_q)
		else $error("pattern error reported without marking the pattern bad");

	// After a full match the next attempt starts at the first position.
	a_match_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && emit && res.event_res == spm_pkg::EV_MATCH) |=> (cursor_q == '0))
		else $error("cursor not rewound after a match");

	a_pos_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		pos_count_q <= PCW'(NPOS))
		else $error("position count exceeds the table size");

	a_term_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		cur_terms_q <= TCW'(NTERM))
		else $error("class term count exceeds the row size");

endmodule
`default_nettype wire
